### design/dsp_pkg.sv
`default_nettype none
package dsp_pkg;

  // root widths of the two pipelined square roots
  localparam int D1_W = 32;
  localparam int D2_W = 36;
  // quotient bits kept by the pixel divider (limit is +-2^40)
  localparam int Q_W = 41;

  localparam logic [2:0] REG_FOCAL_X = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_SHIFT = 3'd4;
  localparam logic [2:0] REG_ALPHA = 3'd5;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  localparam logic signed [41:0] QLIM_POS = 42'h100_0000_0000;
  localparam logic signed [41:0] QLIM_NEG = 42'h300_0000_0000;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [17:0] xi;
    logic [16:0] alpha;
    logic signed [35:0] w2;
  } cfg_t;

  typedef struct packed {
    logic ok;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [36:0] nrm;
  } nrm_t;

endpackage
`default_nettype wire

### design/double_sphere_project_core.sv
// channel  | ports                                      | dir | handshake
// ---------+--------------------------------------------+-----+-------------------
// input    | in_point_x/y/z                             | in  | in_valid/in_ready
// result   | out_pixel_u/v, out_in_view                 | out | out_valid/out_ready
// config   | psel penable pwrite paddr pwdata prdata    | i/o | pready tied high
//
// one word per cycle while in_ready is high; latency is set by the two one-bit-per-stage
// root pipelines and the 41-stage pixel divider.
// after reset, and after a write to sphere_shift or blend_alpha, a sequential
// unit rebuilds w2; in_ready stays low meanwhile.
// one skid word behind the output register; the whole pipe holds only when it is full.
`default_nettype none
module double_sphere_project_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pixel_u,
  output logic signed [31:0] out_pixel_v,
  output logic               out_in_view,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dsp_pkg::cfg_t cfg;
  dsp_pkg::nrm_t g_d;
  logic busy, en, g_v, d_v, d_view;
  logic signed [31:0] d_u, d_v2;

  logic out_v_r, skid_v_r;
  logic signed [31:0] out_u_r, out_vv_r, skid_u_r, skid_vv_r;
  logic out_view_r, skid_view_r;
  logic take;

  assign pready = 1'b1;
  assign en = !skid_v_r;
  assign in_ready = en && !busy;

  dsp_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .busy(busy), .cfg(cfg)
  );

  dsp_geom u_geom (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid && in_ready),
    .x(in_point_x), .y(in_point_y), .z(in_point_z), .cfg(cfg),
    .out_v(g_v), .out_d(g_d)
  );

  dsp_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(g_v), .in_d(g_d), .cfg(cfg),
    .out_v(d_v), .pixel_u(d_u), .pixel_v(d_v2), .in_view(d_view)
  );

  assign take = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= en && d_v;
      end
    end else if (en && d_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_u_r <= skid_u_r;
        out_vv_r <= skid_vv_r;
        out_view_r <= skid_view_r;
      end else begin
        out_u_r <= d_u;
        out_vv_r <= d_v2;
        out_view_r <= d_view;
      end
    end else if (en && d_v) begin
      // output word still waiting, park the new one
      skid_u_r <= d_u;
      skid_vv_r <= d_v2;
      skid_view_r <= d_view;
    end
  end

  assign out_valid = out_v_r;
  assign out_pixel_u = out_u_r;
  assign out_pixel_v = out_vv_r;
  assign out_in_view = out_view_r;

endmodule
`default_nettype wire

### design/dsp_cfg.sv
`default_nettype none
module dsp_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            busy,
  output dsp_pkg::cfg_t   cfg
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_W1 = 3'd2;
  localparam logic [2:0] ST_MUL = 3'd3;
  localparam logic [2:0] ST_RAD = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_W2 = 3'd6;
  localparam logic [2:0] ST_FIX = 3'd7;

  logic [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [17:0] shift_r;
  logic [16:0] alpha_r;
  logic [16:0] a_eff;
  logic wr, wr_shape;

  logic [2:0] state_r;
  logic [34:0] num_r, quo_r;
  logic [17:0] den_r;
  logic [18:0] rem_r;
  logic [5:0] cnt_r;
  logic [16:0] w1_r;
  logic signed [35:0] t1_r;
  logic [35:0] t2_r, rad_r;
  logic [17:0] root_r;
  logic neg_r;
  logic signed [35:0] w2_r;

  logic [18:0] rem_sh, rem_nx;
  logic [34:0] quo_nx;
  logic ge;
  logic [17:0] cand, root_nx;
  logic [35:0] sq;
  logic signed [37:0] rad_s;
  logic signed [18:0] sumw, sumw_abs;
  logic [16:0] p_v, q_v;

  assign wr = psel & penable & pwrite;
  assign wr_shape = wr & ((paddr[4:2] == dsp_pkg::REG_SHIFT) |
                          (paddr[4:2] == dsp_pkg::REG_ALPHA));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= 32'd32768000;
      focal_y_r <= 32'd32768000;
      center_x_r <= 32'd20971520;
      center_y_r <= 32'd15728640;
      shift_r <= '0;
      alpha_r <= dsp_pkg::HALF_Q16;
    end else if (wr) begin
      unique case (paddr[4:2])
        dsp_pkg::REG_FOCAL_X: focal_x_r <= pwdata;
        dsp_pkg::REG_FOCAL_Y: focal_y_r <= pwdata;
        dsp_pkg::REG_CENTER_X: center_x_r <= pwdata;
        dsp_pkg::REG_CENTER_Y: center_y_r <= pwdata;
        dsp_pkg::REG_SHIFT: shift_r <= pwdata[17:0];
        dsp_pkg::REG_ALPHA: alpha_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      dsp_pkg::REG_FOCAL_X: prdata = focal_x_r;
      dsp_pkg::REG_FOCAL_Y: prdata = focal_y_r;
      dsp_pkg::REG_CENTER_X: prdata = center_x_r;
      dsp_pkg::REG_CENTER_Y: prdata = center_y_r;
      dsp_pkg::REG_SHIFT: prdata = {14'd0, shift_r};
      dsp_pkg::REG_ALPHA: prdata = {15'd0, alpha_r};
      default: prdata = '0;
    endcase
  end

  // alpha above one acts as one
  assign a_eff = (alpha_r > dsp_pkg::ONE_Q16) ? dsp_pkg::ONE_Q16 : alpha_r;

  always_comb begin
    if (a_eff > dsp_pkg::HALF_Q16) begin
      p_v = dsp_pkg::ONE_Q16 - a_eff;
      q_v = a_eff;
    end else begin
      p_v = a_eff;
      q_v = dsp_pkg::ONE_Q16 - a_eff;
    end
  end

  // shared restoring divider, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_r[17:0], num_r[34]};
    ge = (rem_sh >= {1'b0, den_r});
    rem_nx = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
    quo_nx = {quo_r[33:0], ge};
  end

  always_comb begin
    cand = root_r | (18'd1 << cnt_r[4:0]);
    sq = cand * cand;
    root_nx = (sq <= rad_r) ? cand : root_r;
    rad_s = ($signed({{2{t1_r[35]}}, t1_r}) <<< 1) + $signed({2'b00, t2_r})
            + $signed(38'h1_0000_0000);
    sumw = $signed({2'b00, w1_r}) + $signed({shift_r[17], shift_r});
    sumw_abs = sumw[18] ? -sumw : sumw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else if (wr_shape) begin
      state_r <= ST_LOAD;
    end else begin
      unique case (state_r)
        ST_IDLE: ;
        ST_LOAD: begin
          num_r <= {2'b00, p_v, 16'd0};
          den_r <= {1'b0, q_v};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= 6'd34;
          state_r <= ST_W1;
        end
        ST_W1: begin
          num_r <= {num_r[33:0], 1'b0};
          rem_r <= rem_nx;
          quo_r <= quo_nx;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            w1_r <= quo_nx[16:0];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          t1_r <= $signed({1'b0, w1_r}) * $signed(shift_r);
          t2_r <= 36'($signed(shift_r) * $signed(shift_r));
          state_r <= ST_RAD;
        end
        ST_RAD: begin
          rad_r <= rad_s[37] ? '0 : rad_s[35:0];
          root_r <= '0;
          cnt_r <= 6'd17;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          root_r <= root_nx;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            if (root_nx == '0) begin
              // zero radicand
              w2_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              num_r <= {1'b0, sumw_abs[17:0], 16'd0};
              den_r <= root_nx;
              neg_r <= sumw[18];
              rem_r <= '0;
              quo_r <= '0;
              cnt_r <= 6'd34;
              state_r <= ST_W2;
            end
          end
        end
        ST_W2: begin
          num_r <= {num_r[33:0], 1'b0};
          rem_r <= rem_nx;
          quo_r <= quo_nx;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) state_r <= ST_FIX;
        end
        ST_FIX: begin
          // floor for a negative quotient
          w2_r <= neg_r ? $signed(~{1'b0, quo_r} + {35'd0, (rem_r == '0)})
                        : $signed({1'b0, quo_r});
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cfg.focal_x = focal_x_r;
    cfg.focal_y = focal_y_r;
    cfg.center_x = $signed(center_x_r);
    cfg.center_y = $signed(center_y_r);
    cfg.xi = $signed(shift_r);
    cfg.alpha = a_eff;
    cfg.w2 = w2_r;
  end

endmodule
`default_nettype wire

### design/dsp_geom.sv
`default_nettype none
module dsp_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic signed [31:0]  x,
  input  logic signed [31:0]  y,
  input  logic signed [31:0]  z,
  input  dsp_pkg::cfg_t       cfg,
  output logic                out_v,
  output dsp_pkg::nrm_t       out_d
);

  localparam int W1 = dsp_pkg::D1_W;
  localparam int W2 = dsp_pkg::D2_W;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0] r2;
  } sb1_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [34:0] k;
    logic ok;
  } sb2_t;

  // squares
  logic s1_v_r;
  logic [63:0] s1_xx_r, s1_yy_r, s1_zz_r;
  logic signed [31:0] s1_x_r, s1_y_r, s1_z_r;
  logic [31:0] ax, ay, az;
  // sums
  logic s2_v_r;
  logic [63:0] s2_sum_r;
  sb1_t s2_sb_r;

  // first root, d1
  logic [W1-1:0] q1_v_r, q1_v_in;
  logic [63:0] q1_rad_r [W1];
  logic [63:0] q1_rad_in [W1];
  logic [63:0] q1_rad_nxt [W1];
  logic [W1-1:0] q1_root_r [W1];
  logic [W1-1:0] q1_root_in [W1];
  logic [W1-1:0] q1_root_nxt [W1];
  logic [W1+2:0] q1_rem_r [W1];
  logic [W1+2:0] q1_rem_in [W1];
  logic [W1+2:0] q1_rem_nxt [W1];
  sb1_t q1_sb_r [W1];
  sb1_t q1_sb_in [W1];

  // k and validity products
  logic s3_v_r;
  logic signed [50:0] s3_xid_r, s3_wph_r;
  logic [49:0] s3_wpl_r;
  sb1_t s3_sb_r;
  logic [W1-1:0] d1;

  logic s4_v_r;
  logic signed [34:0] s4_k_r;
  logic s4_ok_r;
  sb1_t s4_sb_r;
  logic signed [69:0] vtest;

  logic s5_v_r;
  logic [33:0] s5_hh_r, s5_hl_r, s5_ll_r;
  logic signed [34:0] s5_k_r;
  logic s5_ok_r;
  sb1_t s5_sb_r;
  logic [33:0] kmag;

  logic s6_v_r;
  logic [71:0] s6_rad_r;
  sb2_t s6_sb_r;
  logic [67:0] ksq;

  // second root, d2
  logic [W2-1:0] q2_v_r, q2_v_in;
  logic [71:0] q2_rad_r [W2];
  logic [71:0] q2_rad_in [W2];
  logic [71:0] q2_rad_nxt [W2];
  logic [W2-1:0] q2_root_r [W2];
  logic [W2-1:0] q2_root_in [W2];
  logic [W2-1:0] q2_root_nxt [W2];
  logic [W2+2:0] q2_rem_r [W2];
  logic [W2+2:0] q2_rem_in [W2];
  logic [W2+2:0] q2_rem_nxt [W2];
  sb2_t q2_sb_r [W2];
  sb2_t q2_sb_in [W2];

  // norm blend
  logic s7_v_r;
  logic [52:0] s7_na_r;
  logic signed [52:0] s7_nb_r;
  sb2_t s7_sb_r;
  logic [16:0] om;

  logic s8_v_r;
  dsp_pkg::nrm_t s8_d_r;
  logic signed [53:0] nsum;
  logic signed [37:0] nrm;

  assign ax = x[31] ? (~x + 32'd1) : x;
  assign ay = y[31] ? (~y + 32'd1) : y;
  assign az = z[31] ? (~z + 32'd1) : z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xx_r <= ax * ax;
      s1_yy_r <= ay * ay;
      s1_zz_r <= az * az;
      s1_x_r <= x;
      s1_y_r <= y;
      s1_z_r <= z;
      s2_sum_r <= s1_xx_r + s1_yy_r + s1_zz_r;
      s2_sb_r.x <= s1_x_r;
      s2_sb_r.y <= s1_y_r;
      s2_sb_r.z <= s1_z_r;
      s2_sb_r.r2 <= s1_xx_r + s1_yy_r;
    end
  end

  // digit-by-digit root, one result bit per stage
  always_comb begin
    q1_v_in[0] = s2_v_r;
    q1_rad_in[0] = s2_sum_r;
    q1_root_in[0] = '0;
    q1_rem_in[0] = '0;
    q1_sb_in[0] = s2_sb_r;
    for (int i = 1; i < W1; i++) begin
      q1_v_in[i] = q1_v_r[i-1];
      q1_rad_in[i] = q1_rad_r[i-1];
      q1_root_in[i] = q1_root_r[i-1];
      q1_rem_in[i] = q1_rem_r[i-1];
      q1_sb_in[i] = q1_sb_r[i-1];
    end
  end

  always_comb begin
    logic [W1+2:0] rt, trial;
    for (int i = 0; i < W1; i++) begin
      rt = {q1_rem_in[i][W1:0], q1_rad_in[i][63:62]};
      trial = {1'b0, q1_root_in[i], 2'b01};
      if (rt >= trial) begin
        q1_rem_nxt[i] = rt - trial;
        q1_root_nxt[i] = {q1_root_in[i][W1-2:0], 1'b1};
      end else begin
        q1_rem_nxt[i] = rt;
        q1_root_nxt[i] = {q1_root_in[i][W1-2:0], 1'b0};
      end
      q1_rad_nxt[i] = {q1_rad_in[i][61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= '0;
    end else if (en) begin
      q1_v_r <= q1_v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W1; i++) begin
        q1_rad_r[i] <= q1_rad_nxt[i];
        q1_root_r[i] <= q1_root_nxt[i];
        q1_rem_r[i] <= q1_rem_nxt[i];
        q1_sb_r[i] <= q1_sb_in[i];
      end
    end
  end

  assign d1 = q1_root_r[W1-1];

  always_comb begin
    vtest = $signed({{22{s3_sb_r.z[31]}}, s3_sb_r.z, 16'd0})
          + $signed({s3_wph_r[50], s3_wph_r, 18'd0})
          + $signed({20'd0, s3_wpl_r});
    kmag = s4_k_r[34] ? 34'(~s4_k_r + 35'd1) : s4_k_r[33:0];
    ksq = {s5_hh_r, 34'd0} + {16'd0, s5_hl_r, 18'd0} + {34'd0, s5_ll_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= q1_v_r[W1-1];
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_xid_r <= $signed(cfg.xi) * $signed({1'b0, d1});
      s3_wph_r <= $signed(cfg.w2[35:18]) * $signed({1'b0, d1});
      s3_wpl_r <= cfg.w2[17:0] * d1;
      s3_sb_r <= q1_sb_r[W1-1];
      // floor of xi*d1 / 2^16, plus z
      s4_k_r <= $signed(s3_xid_r[50:16]) + $signed({{3{s3_sb_r.z[31]}}, s3_sb_r.z});
      s4_ok_r <= !vtest[69] && (vtest != '0);
      s4_sb_r <= s3_sb_r;
      s5_hh_r <= kmag[33:17] * kmag[33:17];
      s5_hl_r <= kmag[33:17] * kmag[16:0];
      s5_ll_r <= kmag[16:0] * kmag[16:0];
      s5_k_r <= s4_k_r;
      s5_ok_r <= s4_ok_r;
      s5_sb_r <= s4_sb_r;
      s6_rad_r <= {8'd0, s5_sb_r.r2} + {4'd0, ksq};
      s6_sb_r.x <= s5_sb_r.x;
      s6_sb_r.y <= s5_sb_r.y;
      s6_sb_r.k <= s5_k_r;
      s6_sb_r.ok <= s5_ok_r;
    end
  end

  always_comb begin
    q2_v_in[0] = s6_v_r;
    q2_rad_in[0] = s6_rad_r;
    q2_root_in[0] = '0;
    q2_rem_in[0] = '0;
    q2_sb_in[0] = s6_sb_r;
    for (int i = 1; i < W2; i++) begin
      q2_v_in[i] = q2_v_r[i-1];
      q2_rad_in[i] = q2_rad_r[i-1];
      q2_root_in[i] = q2_root_r[i-1];
      q2_rem_in[i] = q2_rem_r[i-1];
      q2_sb_in[i] = q2_sb_r[i-1];
    end
  end

  always_comb begin
    logic [W2+2:0] rt, trial;
    for (int i = 0; i < W2; i++) begin
      rt = {q2_rem_in[i][W2:0], q2_rad_in[i][71:70]};
      trial = {1'b0, q2_root_in[i], 2'b01};
      if (rt >= trial) begin
        q2_rem_nxt[i] = rt - trial;
        q2_root_nxt[i] = {q2_root_in[i][W2-2:0], 1'b1};
      end else begin
        q2_rem_nxt[i] = rt;
        q2_root_nxt[i] = {q2_root_in[i][W2-2:0], 1'b0};
      end
      q2_rad_nxt[i] = {q2_rad_in[i][69:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_v_r <= '0;
    end else if (en) begin
      q2_v_r <= q2_v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W2; i++) begin
        q2_rad_r[i] <= q2_rad_nxt[i];
        q2_root_r[i] <= q2_root_nxt[i];
        q2_rem_r[i] <= q2_rem_nxt[i];
        q2_sb_r[i] <= q2_sb_in[i];
      end
    end
  end

  assign om = dsp_pkg::ONE_Q16 - cfg.alpha;

  always_comb begin
    nsum = $signed({1'b0, s7_na_r}) + $signed({s7_nb_r[52], s7_nb_r});
    nrm = nsum[53:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= q2_v_r[W2-1];
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_na_r <= cfg.alpha * q2_root_r[W2-1];
      s7_nb_r <= $signed({1'b0, om}) * q2_sb_r[W2-1].k;
      s7_sb_r <= q2_sb_r[W2-1];
      s8_d_r.ok <= s7_sb_r.ok && !nrm[37] && (nrm != '0);
      s8_d_r.x <= s7_sb_r.x;
      s8_d_r.y <= s7_sb_r.y;
      s8_d_r.nrm <= nrm[36:0];
    end
  end

  assign out_v = s8_v_r;
  assign out_d = s8_d_r;

endmodule
`default_nettype wire

### design/dsp_div.sv
`default_nettype none
module dsp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  dsp_pkg::nrm_t       in_d,
  input  dsp_pkg::cfg_t       cfg,
  output logic                out_v,
  output logic signed [31:0]  pixel_u,
  output logic signed [31:0]  pixel_v,
  output logic                in_view
);

  localparam int QW = dsp_pkg::Q_W;

  typedef struct packed {
    logic [36:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic neg;
    logic ovf;
  } lane_t;

  function automatic lane_t lane_prep(logic signed [63:0] p, logic [36:0] den);
    logic [63:0] nu;
    lane_t o;
    nu = p[63] ? (~p + 64'd1) : p;
    o.neg = p[63];
    // quotient at or above 2^41 only ever clamps
    o.ovf = ({14'd0, nu[63:QW]} >= den);
    o.rem = o.ovf ? '0 : {14'd0, nu[63:QW]};
    o.low = nu[QW-1:0];
    o.quo = '0;
    return o;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [36:0] den);
    logic [37:0] rt;
    lane_t o;
    o = l;
    rt = {l.rem, l.low[QW-1]};
    if (rt >= {1'b0, den}) begin
      o.rem = 37'(rt - {1'b0, den});
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = rt[36:0];
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    o.low = {l.low[QW-2:0], 1'b0};
    return o;
  endfunction

  function automatic logic signed [41:0] lane_fin(lane_t l);
    logic big;
    logic signed [41:0] q;
    big = l.ovf | l.quo[QW-1];
    if (!l.neg) begin
      q = big ? dsp_pkg::QLIM_POS : $signed({1'b0, l.quo});
    end else begin
      // floor: -Q, one less when the division was inexact
      q = big ? dsp_pkg::QLIM_NEG : $signed(~{1'b0, l.quo} + {41'd0, (l.rem == '0)});
    end
    return q;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [41:0] q,
                                                logic signed [31:0] c);
    logic signed [42:0] s;
    logic signed [31:0] r;
    s = $signed({q[41], q}) + $signed({{11{c[31]}}, c});
    if (s[42:31] == {12{s[42]}}) r = s[31:0];
    else r = s[42] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    return r;
  endfunction

  logic d1_v_r, d1_ok_r;
  logic signed [63:0] d1_pu_r, d1_pv_r;
  logic [36:0] d1_den_r;

  logic d2_v_r, d2_ok_r;
  lane_t d2_u_r, d2_v2_r;
  logic [36:0] d2_den_r;

  logic [QW-1:0] q_v_r, q_v_in, q_ok_r, q_ok_in;
  lane_t q_u_r [QW];
  lane_t q_u_in [QW];
  lane_t q_u_nxt [QW];
  lane_t q_w_r [QW];
  lane_t q_w_in [QW];
  lane_t q_w_nxt [QW];
  logic [36:0] q_den_r [QW];
  logic [36:0] q_den_in [QW];

  logic d3_v_r, d3_ok_r;
  logic signed [41:0] d3_qu_r, d3_qv_r;

  logic d4_v_r, d4_ok_r;
  logic signed [31:0] d4_u_r, d4_pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= in_v;
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_pu_r <= $signed({1'b0, cfg.focal_x}) * in_d.x;
      d1_pv_r <= $signed({1'b0, cfg.focal_y}) * in_d.y;
      // keep the divider harmless on invalid points
      d1_den_r <= in_d.ok ? in_d.nrm : 37'd1;
      d1_ok_r <= in_d.ok;
      d2_u_r <= lane_prep(d1_pu_r, d1_den_r);
      d2_v2_r <= lane_prep(d1_pv_r, d1_den_r);
      d2_den_r <= d1_den_r;
      d2_ok_r <= d1_ok_r;
    end
  end

  always_comb begin
    q_v_in[0] = d2_v_r;
    q_ok_in[0] = d2_ok_r;
    q_u_in[0] = d2_u_r;
    q_w_in[0] = d2_v2_r;
    q_den_in[0] = d2_den_r;
    for (int i = 1; i < QW; i++) begin
      q_v_in[i] = q_v_r[i-1];
      q_ok_in[i] = q_ok_r[i-1];
      q_u_in[i] = q_u_r[i-1];
      q_w_in[i] = q_w_r[i-1];
      q_den_in[i] = q_den_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      q_u_nxt[i] = lane_step(q_u_in[i], q_den_in[i]);
      q_w_nxt[i] = lane_step(q_w_in[i], q_den_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= '0;
    end else if (en) begin
      q_v_r <= q_v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_ok_r <= q_ok_in;
      for (int i = 0; i < QW; i++) begin
        q_u_r[i] <= q_u_nxt[i];
        q_w_r[i] <= q_w_nxt[i];
        q_den_r[i] <= q_den_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_v_r <= 1'b0;
      d4_v_r <= 1'b0;
    end else if (en) begin
      d3_v_r <= q_v_r[QW-1];
      d4_v_r <= d3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_qu_r <= lane_fin(q_u_r[QW-1]);
      d3_qv_r <= lane_fin(q_w_r[QW-1]);
      d3_ok_r <= q_ok_r[QW-1];
      d4_u_r <= d3_ok_r ? sat_add(d3_qu_r, cfg.center_x) : '0;
      d4_pv_r <= d3_ok_r ? sat_add(d3_qv_r, cfg.center_y) : '0;
      d4_ok_r <= d3_ok_r;
    end
  end

  assign out_v = d4_v_r;
  assign pixel_u = d4_u_r;
  assign pixel_v = d4_pv_r;
  assign in_view = d4_ok_r;

endmodule
`default_nettype wire
